### rtl/mwdiv_pkg.sv
// shared types for the multiword divide-by-word core
package mwdiv_pkg;
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } mwdiv_state_t;
endpackage

### rtl/multiword_divide_by_word_core.sv
// multiword divide-by-word core: streaming restoring division of a limb sequence by one limb
// Divides a multi-limb unsigned dividend, most significant limb first, by a configured
// nonzero single-limb divisor. Each limb transaction yields one result: the quotient limb,
// the running remainder, and last copied from final_limb; after the final limb the remainder
// is cleared for the next dividend. One shared subtract-and-compare unit retires one quotient
// bit per cycle, and the next limb is accepted only once the result register has been taken
// (or in the same cycle it is taken). A divisor write whose low LIMB_WIDTH bits are zero is
// ignored; any other write also clears the remainder carried into the next limb.
module multiword_divide_by_word_core
  import mwdiv_pkg::*;
#(
  parameter int LIMB_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] dividend_limb,
  input  logic        final_limb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] quotient_limb,
  output logic [63:0] running_remainder,
  output logic        last
);
  localparam int CW = $clog2(LIMB_WIDTH + 1);
  localparam logic [CW-1:0] LastCount = CW'(LIMB_WIDTH - 1);

  mwdiv_state_t state, state_next;
  logic [LIMB_WIDTH-1:0] divisor;
  logic [LIMB_WIDTH-1:0] partial_remainder;
  logic [LIMB_WIDTH-1:0] rem;
  logic [LIMB_WIDTH-1:0] quo;   // shifts in quotient bits while shifting out dividend bits
  logic [CW-1:0] count;
  logic fin;

  logic in_take, out_take, step_done;
  logic [LIMB_WIDTH:0] shifted;
  logic [LIMB_WIDTH:0] diff;
  logic sub_ok;
  logic [LIMB_WIDTH-1:0] cfg_v;

  assign cfg_v = cfg_data[LIMB_WIDTH-1:0];
  assign in_stall = !(state == ST_IDLE || (state == ST_DONE && !out_stall));
  assign in_take = in_valid && !in_stall;
  assign out_valid = (state == ST_DONE);
  assign out_take = out_valid && !out_stall;
  assign step_done = (state == ST_RUN) && (count == LastCount);

  // shared unit: shift in next dividend bit, trial subtract
  assign shifted = {rem, quo[LIMB_WIDTH-1]};
  assign diff = shifted - {1'b0, divisor};
  assign sub_ok = !diff[LIMB_WIDTH];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = ST_RUN;
      ST_RUN: if (step_done) state_next = ST_DONE;
      ST_DONE: begin
        if (in_take) state_next = ST_RUN;
        else if (out_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= LIMB_WIDTH'(1);
      partial_remainder <= '0;
    end else if (cfg_we && cfg_v != '0) begin
      divisor <= cfg_v;
      partial_remainder <= '0;
    end else if (step_done) begin
      // remainder after final bit, cleared at end of dividend
      partial_remainder <= fin ? '0 :
        (sub_ok ? diff[LIMB_WIDTH-1:0] : shifted[LIMB_WIDTH-1:0]);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      rem <= partial_remainder;
      quo <= dividend_limb[LIMB_WIDTH-1:0];
      fin <= final_limb;
      count <= '0;
    end else if (state == ST_RUN) begin
      rem <= sub_ok ? diff[LIMB_WIDTH-1:0] : shifted[LIMB_WIDTH-1:0];
      quo <= {quo[LIMB_WIDTH-2:0], sub_ok};
      count <= count + CW'(1);
    end
  end

  assign quotient_limb = 64'(quo);
  assign running_remainder = 64'(rem);
  assign last = fin;

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (rem < divisor)) else $error("remainder not below divisor");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    step_done |=> (state == ST_DONE)) else $error("run did not finish");
  a_no_take_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> in_stall) else $error("input taken mid run");
  a_div_nz: assert property (@(posedge clk) disable iff (rst)
    divisor != '0) else $error("zero divisor");
endmodule
